/* hdl/scxf_pkg.sv */
// ----------------------------------------------------------------------------
// scxf_pkg: shared types and constants for the schedule crossfade pixel block
// Phase codes, the phase decode struct, register indexes and blend constants.
// ----------------------------------------------------------------------------
package scxf_pkg;

   // Schedule phases, in the order in which they are tested.
   typedef enum logic [2:0] {
      PH_NIGHT_EARLY = 3'd0,
      PH_FADE_UP     = 3'd1,
      PH_DAY         = 3'd2,
      PH_FADE_DOWN   = 3'd3,
      PH_NIGHT_LATE  = 3'd4
   } phase_type;

   // Decoded phase: code, fade flag and which color each blend end uses.
   typedef struct packed {
      phase_type phase;
      logic      fade;
      logic      from_day;
      logic      to_day;
   } phase_info_type;

   // Configuration register indexes.
   typedef enum logic [2:0] {
      CSR_WAKE_HOUR    = 3'd0,
      CSR_WAKE_MINUTE  = 3'd1,
      CSR_SLEEP_HOUR   = 3'd2,
      CSR_SLEEP_MINUTE = 3'd3,
      CSR_NIGHT_RGBL   = 3'd4,
      CSR_DAY_RGBL     = 3'd5
   } csr_index_type;

   localparam int CSR_DATA_W = 32;

   localparam logic [4:0] HOUR_LAST   = 5'd23;
   localparam logic [5:0] MINUTE_LAST = 6'd59;
   localparam logic [5:0] SECOND_MAX  = 6'd59;
   localparam logic [5:0] FADE_SPAN   = 6'd60;
   localparam logic [7:0] BRI_FLOOR   = 8'd2;

   localparam logic [4:0] WAKE_HOUR_RST  = 5'd7;
   localparam logic [4:0] SLEEP_HOUR_RST = 5'd19;

   // Blend sums are at most 255 * 60, which fits in 14 bits.
   localparam int SUM_W = 14;

   // Division by 60 as a multiply by ceil(2^20 / 60) and a shift; exact for
   // every sum below 2^20 / 44, which covers the whole blend range.
   localparam int         DIV60_SHIFT = 20;
   localparam logic [14:0] DIV60_MUL  = 15'd17477;
   localparam int         DIV60_PROD_W = SUM_W + 15;

   localparam int LANES = 4;

endpackage

/* hdl/schedule_crossfade_pixel_color_top.sv */
// ----------------------------------------------------------------------------
// schedule_crossfade_pixel_color_top: day/night pixel color generator
// Gives a pixel's color, the panel brightness and the schedule phase for a
// time of day and a pixel coordinate, with one-minute crossfades.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake           Contents
//   request   start / busy        hour, minute, second, day of month, column, row
//   response  rsp_strobe          red, green, blue, brightness, phase
//   csr       csr_we              csr_index, csr_wdata (write only)
//
// A request is taken at every clock edge where start is high and busy is low,
// so one request per cycle is sustained. Its response shows on the rsp_ ports
// for one cycle. It passes through the input register, then the register of the
// phase decode and channel sums, and then the register of the quotients by 60
// with the output masking.
// The response side cannot stall, so the pipeline never holds. Busy is high
// only during reset. Reset clears the pipeline valids and loads the schedule
// registers with their defaults.
//
module schedule_crossfade_pixel_color_top #(
   parameter int GRID_COLUMNS = 16,
   parameter int GRID_ROWS    = 16
) (
   input  logic                      clock,
   input  logic                      reset,

   input  logic                      start,
   output logic                      busy,
   input  logic [4:0]                req_hour,
   input  logic [5:0]                req_minute,
   input  logic [5:0]                req_second,
   input  logic [4:0]                req_day_of_month,
   input  logic [5:0]                req_column,
   input  logic [5:0]                req_row,

   output logic                      rsp_strobe,
   output logic [7:0]                rsp_red,
   output logic [7:0]                rsp_green,
   output logic [7:0]                rsp_blue,
   output logic [7:0]                rsp_brightness,
   output logic [2:0]                rsp_phase,

   input  logic                      csr_we,
   input  logic [2:0]                csr_index,
   input  logic [scxf_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import scxf_pkg::*;

   // Schedule and color registers.
   logic [4:0]  wake_hour_ff;
   logic [5:0]  wake_minute_ff;
   logic [4:0]  sleep_hour_ff;
   logic [5:0]  sleep_minute_ff;
   logic [31:0] night_rgbl_ff;
   logic [31:0] day_rgbl_ff;

   // Input register stage.
   logic        in_valid_ff;
   logic [4:0]  hour_ff;
   logic [5:0]  minute_ff;
   logic [5:0]  second_ff;
   logic [4:0]  day_ff;
   logic [5:0]  column_ff;
   logic [5:0]  row_ff;

   // Sum stage.
   logic                  s1_valid_ff;
   logic [SUM_W-1:0]      s1_sum_ff [LANES];
   logic [SUM_W-1:0]      s1_sum_in [LANES];
   phase_type             s1_phase_ff;
   logic                  s1_fade_ff;
   logic                  s1_lit_ff;
   logic                  s1_lit_in;

   // Result stage.
   logic        rsp_strobe_ff;
   logic [7:0]  rsp_red_ff;
   logic [7:0]  rsp_green_ff;
   logic [7:0]  rsp_blue_ff;
   logic [7:0]  rsp_brightness_ff;
   logic [2:0]  rsp_phase_ff;

   phase_info_type info;
   logic [5:0]     weight;
   logic [31:0]    from_rgbl;
   logic [31:0]    to_rgbl;
   logic [7:0]     quotient [LANES];
   logic [7:0]     bri_in;
   logic           accept;

   // No request is taken while reset is held.
   assign busy   = reset;
   assign accept = start && !busy;

   // Configuration writes; an index past the register list is ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         wake_hour_ff    <= WAKE_HOUR_RST;
         wake_minute_ff  <= 6'd0;
         sleep_hour_ff   <= SLEEP_HOUR_RST;
         sleep_minute_ff <= 6'd0;
         night_rgbl_ff   <= 32'd0;
         day_rgbl_ff     <= 32'd0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_WAKE_HOUR:    wake_hour_ff    <= csr_wdata[4:0];
            CSR_WAKE_MINUTE:  wake_minute_ff  <= csr_wdata[5:0];
            CSR_SLEEP_HOUR:   sleep_hour_ff   <= csr_wdata[4:0];
            CSR_SLEEP_MINUTE: sleep_minute_ff <= csr_wdata[5:0];
            CSR_NIGHT_RGBL:   night_rgbl_ff   <= csr_wdata[31:0];
            CSR_DAY_RGBL:     day_rgbl_ff     <= csr_wdata[31:0];
            default: begin
            end
         endcase
      end
   end

   // Capture the request.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= accept;
      end
      if (accept) begin
         hour_ff   <= req_hour;
         minute_ff <= req_minute;
         second_ff <= req_second;
         day_ff    <= req_day_of_month;
         column_ff <= req_column;
         row_ff    <= req_row;
      end
   end

   scxf_phase u_phase (
      .hour         (hour_ff),
      .minute       (minute_ff),
      .wake_hour    (wake_hour_ff),
      .wake_minute  (wake_minute_ff),
      .sleep_hour   (sleep_hour_ff),
      .sleep_minute (sleep_minute_ff),
      .info         (info)
   );

   // The second is the fade weight and saturates at 59. Outside the fades
   // both blend ends carry the same color, so the blend returns it unchanged.
   assign weight    = (second_ff > SECOND_MAX) ? SECOND_MAX : second_ff;
   assign from_rgbl = info.from_day ? day_rgbl_ff : night_rgbl_ff;
   assign to_rgbl   = info.to_day   ? day_rgbl_ff : night_rgbl_ff;

   // Lane 3 is red, lane 2 green, lane 1 blue and lane 0 brightness.
   for (genvar lane = 0; lane < LANES; lane++) begin : g_lane
      scxf_mix u_mix (
         .from_level (from_rgbl[8*lane +: 8]),
         .to_level   (to_rgbl[8*lane +: 8]),
         .weight     (weight),
         .sum        (s1_sum_in[lane])
      );
      scxf_div60 u_div (
         .sum      (s1_sum_ff[lane]),
         .quotient (quotient[lane])
      );
   end

   // A pixel is lit when it is on the panel and on the checkerboard square
   // that the day's parity selects.
   assign s1_lit_in = ({1'b0, column_ff} < 7'(GRID_COLUMNS)) &&
                      ({1'b0, row_ff} < 7'(GRID_ROWS)) &&
                      !(column_ff[0] ^ row_ff[0] ^ day_ff[0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid_ff;
      end
      s1_sum_ff   <= s1_sum_in;
      s1_phase_ff <= info.phase;
      s1_fade_ff  <= info.fade;
      s1_lit_ff   <= s1_lit_in;
   end

   // Brightness has a floor during the fades only.
   assign bri_in = (s1_fade_ff && quotient[0] < BRI_FLOOR) ? BRI_FLOOR : quotient[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= s1_valid_ff;
      end
      rsp_red_ff        <= s1_lit_ff ? quotient[3] : 8'd0;
      rsp_green_ff      <= s1_lit_ff ? quotient[2] : 8'd0;
      rsp_blue_ff       <= s1_lit_ff ? quotient[1] : 8'd0;
      rsp_brightness_ff <= bri_in;
      rsp_phase_ff      <= s1_phase_ff;
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_red        = rsp_red_ff;
   assign rsp_green      = rsp_green_ff;
   assign rsp_blue       = rsp_blue_ff;
   assign rsp_brightness = rsp_brightness_ff;
   assign rsp_phase      = rsp_phase_ff;

   // Every item in the sum stage reaches the response ports in the next cycle.
   a_stage_to_rsp : assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |=> rsp_strobe)
      else $error("sum stage item did not reach the response ports");

   // During a fade the reported brightness never drops below the floor.
   a_fade_floor : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_phase == PH_FADE_UP || rsp_phase == PH_FADE_DOWN))
      |-> (rsp_brightness >= BRI_FLOOR))
      else $error("fade brightness below floor");

   // An unlit pixel comes out black.
   a_unlit_black : assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_lit_ff)
      |=> (rsp_red == 8'd0 && rsp_green == 8'd0 && rsp_blue == 8'd0))
      else $error("unlit pixel is not black");

endmodule

/* hdl/scxf_phase.sv */
// ----------------------------------------------------------------------------
// scxf_phase: schedule phase decoder
// Compares the time of day against the wake and sleep times and the minute
// that leads each of them, and tells which colors the blend mixes.
// ----------------------------------------------------------------------------
module scxf_phase (
   input  logic [4:0]                hour,
   input  logic [5:0]                minute,
   input  logic [4:0]                wake_hour,
   input  logic [5:0]                wake_minute,
   input  logic [4:0]                sleep_hour,
   input  logic [5:0]                sleep_minute,
   output scxf_pkg::phase_info_type  info
);
   import scxf_pkg::*;

   logic [4:0] wake_lead_hour;
   logic [5:0] wake_lead_minute;
   logic [4:0] sleep_lead_hour;
   logic [5:0] sleep_lead_minute;
   logic       before_wake_lead;
   logic       before_wake;
   logic       before_sleep_lead;
   logic       before_sleep;

   // One minute back; minute zero borrows from the hour, and hour zero wraps.
   always_comb begin
      if (wake_minute == 6'd0) begin
         wake_lead_minute = MINUTE_LAST;
         wake_lead_hour   = (wake_hour == 5'd0) ? HOUR_LAST : wake_hour - 5'd1;
      end else begin
         wake_lead_minute = wake_minute - 6'd1;
         wake_lead_hour   = wake_hour;
      end
      if (sleep_minute == 6'd0) begin
         sleep_lead_minute = MINUTE_LAST;
         sleep_lead_hour   = (sleep_hour == 5'd0) ? HOUR_LAST : sleep_hour - 5'd1;
      end else begin
         sleep_lead_minute = sleep_minute - 6'd1;
         sleep_lead_hour   = sleep_hour;
      end
   end

   assign before_wake_lead  = (hour < wake_lead_hour) ||
                              (hour == wake_lead_hour && minute < wake_lead_minute);
   assign before_wake       = (hour < wake_hour) ||
                              (hour == wake_hour && minute < wake_minute);
   assign before_sleep_lead = (hour < sleep_lead_hour) ||
                              (hour == sleep_lead_hour && minute < sleep_lead_minute);
   assign before_sleep      = (hour < sleep_hour) ||
                              (hour == sleep_hour && minute < sleep_minute);

   always_comb begin
      priority if (before_wake_lead) begin
         info = '{phase: PH_NIGHT_EARLY, fade: 1'b0, from_day: 1'b0, to_day: 1'b0};
      end else if (before_wake) begin
         info = '{phase: PH_FADE_UP, fade: 1'b1, from_day: 1'b0, to_day: 1'b1};
      end else if (before_sleep_lead) begin
         info = '{phase: PH_DAY, fade: 1'b0, from_day: 1'b1, to_day: 1'b1};
      end else if (before_sleep) begin
         info = '{phase: PH_FADE_DOWN, fade: 1'b1, from_day: 1'b1, to_day: 1'b0};
      end else begin
         info = '{phase: PH_NIGHT_LATE, fade: 1'b0, from_day: 1'b0, to_day: 1'b0};
      end
   end

endmodule

/* hdl/scxf_mix.sv */
// ----------------------------------------------------------------------------
// scxf_mix: weighted sum of one color channel
// Forms from * (60 - s) + to * s, the numerator of the crossfade blend.
// ----------------------------------------------------------------------------
module scxf_mix (
   input  logic [7:0]                 from_level,
   input  logic [7:0]                 to_level,
   input  logic [5:0]                 weight,
   output logic [scxf_pkg::SUM_W-1:0] sum
);
   import scxf_pkg::*;

   logic [5:0]       inv_weight;
   logic [SUM_W-1:0] from_part;
   logic [SUM_W-1:0] to_part;

   // The weight is already limited to 59, so this never goes below one.
   assign inv_weight = FADE_SPAN - weight;
   assign from_part  = SUM_W'(from_level) * SUM_W'(inv_weight);
   assign to_part    = SUM_W'(to_level) * SUM_W'(weight);
   assign sum        = from_part + to_part;

endmodule

/* hdl/scxf_div60.sv */
// ----------------------------------------------------------------------------
// scxf_div60: divide a blend sum by 60
// Reciprocal multiply and shift; the quotient of any blend sum fits in one byte.
// ----------------------------------------------------------------------------
module scxf_div60 (
   input  logic [scxf_pkg::SUM_W-1:0] sum,
   output logic [7:0]                 quotient
);
   import scxf_pkg::*;

   logic [DIV60_PROD_W-1:0] product;

   assign product  = DIV60_PROD_W'(sum) * DIV60_PROD_W'(DIV60_MUL);
   assign quotient = product[DIV60_SHIFT +: 8];

endmodule
